// ----- rtl/core/sgd_momentum_weight_update_assert.svh -----
// Assertion macros used by the port checker of the weight update block.
`ifndef SGD_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH
`define SGD_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SGDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgdm port check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SGDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgdm port check failed");

`endif

// ----- rtl/core/sgdm_pkg.sv -----
// Package of the weight update block: widths, register indexes, types, helpers.
`default_nettype none

package sgdm_pkg;

  localparam int VALUE_W    = 32;
  localparam int VALUE_FRAC = 24;
  localparam int COEF_W     = 16;
  localparam int SCALE_W    = 24;
  localparam int SCALE_FRAC = 16;
  localparam int WIDE_W     = 2 * VALUE_W;
  localparam int CFG_IDX_W  = 8;
  localparam int NSTAGE     = 9;

  // Product widths: signed value times a zero-extended unsigned operand.
  localparam int PROD_C_W = VALUE_W + COEF_W + 1;
  localparam int PROD_S_W = VALUE_W + SCALE_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_L2_DECAY        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_L1_DECAY        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = CFG_IDX_W'(3);

  localparam logic signed [WIDE_W-1:0] VMAX_W =
    {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] VMIN_W =
    {{(WIDE_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic                      clip;
    logic signed [VALUE_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] valid;
  } sgdm_pipe_t;

  // Clip a wide value to the signed value range and flag the clip.
  function automatic sat_t sat_fn(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > VMAX_W) begin
      r.clip = 1'b1;
      r.val  = VMAX_W[VALUE_W-1:0];
    end else if (v < VMIN_W) begin
      r.clip = 1'b1;
      r.val  = VMIN_W[VALUE_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[VALUE_W-1:0];
    end
    return r;
  endfunction

  // Drop sh fraction bits, rounding half up.
  function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] p,
                                                        input int unsigned sh);
    logic signed [WIDE_W-1:0] half;
    half = WIDE_W'(1) <<< (sh - 1);
    return (p + half) >>> sh;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sgdm_pipe_ctrl.sv -----
// Valid and enable control of the update pipeline with bubble collapsing.
`default_nettype none

module sgdm_pipe_ctrl
  import sgdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  output sgdm_pipe_t pipe_o
);

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] valid_d;
  logic [NSTAGE-1:0] en;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NSTAGE-1] = !valid_q[NSTAGE-1] || out_ready_i;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NSTAGE; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pipe_o.en    = en;
  assign pipe_o.valid = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/sgd_momentum_weight_update.sv -----
// Top level: pipelined SGD weight update with momentum and L1/L2 decay.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_ready_o   | weight_i, gradient_i, momentum_i, step_scale_i
//  out     | out_valid_o / out_ready_i | new_weight_o, new_gradient_o, new_momentum_o, saturated_o
//
// One request per cycle while the output is not stalled, over nine register stages: four
// multiplier stages, each followed by its own round and saturate stage, and the L1 stage.
// The last round stage is the output register.
// Each stage holds while it is full and the stage after it stalls; empty stages keep filling,
// so new requests are taken while a result waits. Reset clears the valid bits and the
// configuration registers; payload registers are not reset.
// cfg_ready_o is always high; writes take effect at once and are meant for idle.
`default_nettype none

module sgd_momentum_weight_update
  import sgdm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COEF_W-1:0]         cfg_data_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] weight_i,
  input  logic signed [VALUE_W-1:0] gradient_i,
  input  logic signed [VALUE_W-1:0] momentum_i,
  input  logic [SCALE_W-1:0]        step_scale_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] new_weight_o,
  output logic signed [VALUE_W-1:0] new_gradient_o,
  output logic signed [VALUE_W-1:0] new_momentum_o,
  output logic                      saturated_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] eta_q, l2_q, l1_q, kf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q <= '0;
      l2_q  <= '0;
      l1_q  <= '0;
      kf_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEARN_RATE:      eta_q <= cfg_data_i;
        REG_L2_DECAY:        l2_q  <= cfg_data_i;
        REG_L1_DECAY:        l1_q  <= cfg_data_i;
        REG_MOMENTUM_FACTOR: kf_q  <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Decoded configuration, to be kept static by the user while requests are in flight; not enforced here.
  logic                     k_zero;
  logic [COEF_W:0]          k_new;      // 1 - k, exact in COEF_W+1 bits
  logic signed [WIDE_W-1:0] l1_step;    // l1 decay as a Q8.24 value

  assign k_zero  = (kf_q == '0);
  assign k_new   = {1'b1, {COEF_W{1'b0}}} - {1'b0, kf_q};
  assign l1_step = rnd_shr($signed(WIDE_W'(l1_q)) <<< VALUE_FRAC, COEF_W);

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  sgdm_pipe_t pipe;

  sgdm_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .pipe_o      (pipe)
  );

  assign in_ready_o  = pipe.en[0];
  assign out_valid_o = pipe.valid[NSTAGE-1];

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  // stage 0: capture, w * l2
  logic signed [VALUE_W-1:0]  s0_w_q, s0_g_q, s0_m_q;
  logic [SCALE_W-1:0]         s0_sc_q;
  logic signed [PROD_C_W-1:0] s0_pl2_q, s0_pl2_d;
  // stage 1: L2 term added
  logic signed [VALUE_W-1:0]  s1_w_q, s1_g_q, s1_m_q, s1_g_d;
  logic [SCALE_W-1:0]         s1_sc_q;
  logic                       s1_clip_q, s1_clip_d;
  // stage 2: L1 term added
  logic signed [VALUE_W-1:0]  s2_w_q, s2_g_q, s2_m_q, s2_g_d;
  logic [SCALE_W-1:0]         s2_sc_q;
  logic                       s2_clip_q, s2_clip_d;
  // stage 3: g * scale, or (1-k) * g and k * m
  logic signed [VALUE_W-1:0]  s3_w_q, s3_g_q, s3_m_q;
  logic [SCALE_W-1:0]         s3_sc_q;
  logic signed [PROD_S_W-1:0] s3_pa_q, s3_pa_d;
  logic signed [PROD_C_W-1:0] s3_pb_q, s3_pb_d;
  logic                       s3_clip_q;
  // stage 4: scaled gradient, or blended momentum
  logic signed [VALUE_W-1:0]  s4_w_q, s4_m_q, s4_x_q, s4_go_q, s4_x_d, s4_go_d;
  logic [SCALE_W-1:0]         s4_sc_q;
  logic                       s4_clip_q, s4_clip_d;
  // stage 5: blended momentum * scale
  logic signed [VALUE_W-1:0]  s5_w_q, s5_m_q, s5_x_q, s5_go_q;
  logic signed [PROD_S_W-1:0] s5_pc_q, s5_pc_d;
  logic                       s5_clip_q;
  // stage 6: step operand selected
  logic signed [VALUE_W-1:0]  s6_w_q, s6_y_q, s6_go_q, s6_mo_q, s6_y_d, s6_mo_d;
  logic                       s6_clip_q, s6_clip_d;
  // stage 7: step * eta
  logic signed [VALUE_W-1:0]  s7_w_q, s7_go_q, s7_mo_q;
  logic signed [PROD_C_W-1:0] s7_pe_q, s7_pe_d;
  logic                       s7_clip_q;
  // stage 8: output register
  logic signed [VALUE_W-1:0]  s8_nw_q, s8_go_q, s8_mo_q, s8_nw_d;
  logic                       s8_clip_q, s8_clip_d;

  // ---------------------------------------------------------------------------
  // Stage logic
  // ---------------------------------------------------------------------------
  sat_t sat_l2, sat_l1, sat_x, sat_mn, sat_nw;
  logic signed [WIDE_W-1:0] l1_sum;
  logic signed [WIDE_W-1:0] x_pre;

  always_comb begin
    // stage 0: L2 product
    s0_pl2_d = weight_i * $signed({1'b0, l2_q});

    // stage 1: add the rounded L2 term when enabled
    sat_l2    = sat_fn(WIDE_W'(s0_g_q) + rnd_shr(WIDE_W'(s0_pl2_q), COEF_W));
    s1_g_d    = (l2_q != '0) ? sat_l2.val : s0_g_q;
    s1_clip_d = (l2_q != '0) && sat_l2.clip;

    // stage 2: add l1 with the sign of the weight; a zero weight adds nothing
    l1_sum    = s1_w_q[VALUE_W-1] ? (WIDE_W'(s1_g_q) - l1_step)
                                  : (WIDE_W'(s1_g_q) + l1_step);
    sat_l1    = sat_fn(l1_sum);
    if ((l1_q != '0) && (s1_w_q != '0)) begin
      s2_g_d    = sat_l1.val;
      s2_clip_d = s1_clip_q || sat_l1.clip;
    end else begin
      s2_g_d    = s1_g_q;
      s2_clip_d = s1_clip_q;
    end

    // stage 3: one shared multiplier takes either the scale or 1 - k
    s3_pa_d = s2_g_q * $signed({1'b0, (k_zero ? s2_sc_q : SCALE_W'(k_new))});
    s3_pb_d = s2_m_q * $signed({1'b0, kf_q});

    // stage 4: round and clip the scaled gradient or the blended momentum
    x_pre     = k_zero ? rnd_shr(WIDE_W'(s3_pa_q), SCALE_FRAC)
                       : rnd_shr(WIDE_W'(s3_pa_q) + WIDE_W'(s3_pb_q), COEF_W);
    sat_x     = sat_fn(x_pre);
    s4_x_d    = sat_x.val;
    s4_go_d   = k_zero ? sat_x.val : s3_g_q;
    s4_clip_d = s3_clip_q || sat_x.clip;

    // stage 5: scale the blended momentum
    s5_pc_d = s4_x_q * $signed({1'b0, s4_sc_q});

    // stage 6: pick the value that moves the weight
    sat_mn    = sat_fn(rnd_shr(WIDE_W'(s5_pc_q), SCALE_FRAC));
    s6_y_d    = k_zero ? s5_x_q : sat_mn.val;
    s6_mo_d   = k_zero ? s5_m_q : sat_mn.val;
    s6_clip_d = s5_clip_q || (!k_zero && sat_mn.clip);

    // stage 7: step times learning rate
    s7_pe_d = s6_y_q * $signed({1'b0, eta_q});

    // stage 8: new weight
    sat_nw    = sat_fn(WIDE_W'(s7_w_q) - rnd_shr(WIDE_W'(s7_pe_q), COEF_W));
    s8_nw_d   = sat_nw.val;
    s8_clip_d = s7_clip_q || sat_nw.clip;
  end

  // Payload registers: load whenever the stage advances, no reset.
  always_ff @(posedge clk_i) begin
    if (pipe.en[0]) begin
      s0_w_q   <= weight_i;
      s0_g_q   <= gradient_i;
      s0_m_q   <= momentum_i;
      s0_sc_q  <= step_scale_i;
      s0_pl2_q <= s0_pl2_d;
    end
    if (pipe.en[1]) begin
      s1_w_q    <= s0_w_q;
      s1_g_q    <= s1_g_d;
      s1_m_q    <= s0_m_q;
      s1_sc_q   <= s0_sc_q;
      s1_clip_q <= s1_clip_d;
    end
    if (pipe.en[2]) begin
      s2_w_q    <= s1_w_q;
      s2_g_q    <= s2_g_d;
      s2_m_q    <= s1_m_q;
      s2_sc_q   <= s1_sc_q;
      s2_clip_q <= s2_clip_d;
    end
    if (pipe.en[3]) begin
      s3_w_q    <= s2_w_q;
      s3_g_q    <= s2_g_q;
      s3_m_q    <= s2_m_q;
      s3_sc_q   <= s2_sc_q;
      s3_pa_q   <= s3_pa_d;
      s3_pb_q   <= s3_pb_d;
      s3_clip_q <= s2_clip_q;
    end
    if (pipe.en[4]) begin
      s4_w_q    <= s3_w_q;
      s4_m_q    <= s3_m_q;
      s4_sc_q   <= s3_sc_q;
      s4_x_q    <= s4_x_d;
      s4_go_q   <= s4_go_d;
      s4_clip_q <= s4_clip_d;
    end
    if (pipe.en[5]) begin
      s5_w_q    <= s4_w_q;
      s5_m_q    <= s4_m_q;
      s5_x_q    <= s4_x_q;
      s5_go_q   <= s4_go_q;
      s5_pc_q   <= s5_pc_d;
      s5_clip_q <= s4_clip_q;
    end
    if (pipe.en[6]) begin
      s6_w_q    <= s5_w_q;
      s6_y_q    <= s6_y_d;
      s6_go_q   <= s5_go_q;
      s6_mo_q   <= s6_mo_d;
      s6_clip_q <= s6_clip_d;
    end
    if (pipe.en[7]) begin
      s7_w_q    <= s6_w_q;
      s7_go_q   <= s6_go_q;
      s7_mo_q   <= s6_mo_q;
      s7_pe_q   <= s7_pe_d;
      s7_clip_q <= s6_clip_q;
    end
    if (pipe.en[8]) begin
      s8_nw_q   <= s8_nw_d;
      s8_go_q   <= s7_go_q;
      s8_mo_q   <= s7_mo_q;
      s8_clip_q <= s8_clip_d;
    end
  end

  assign new_weight_o   = s8_nw_q;
  assign new_gradient_o = s8_go_q;
  assign new_momentum_o = s8_mo_q;
  assign saturated_o    = s8_clip_q;

endmodule

`default_nettype wire

// ----- rtl/core/sgdm_port_checker.sv -----
// Port-level checks of the weight update block and their bind.
`default_nettype none

`include "sgd_momentum_weight_update_assert.svh"

module sgdm_port_checker
  import sgdm_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [VALUE_W-1:0] new_weight_i,
  input logic signed [VALUE_W-1:0] new_gradient_i,
  input logic signed [VALUE_W-1:0] new_momentum_i,
  input logic                      saturated_i
);

  // A stalled result holds its value until taken.
  `SGDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(new_weight_i) && $stable(new_gradient_i) && $stable(new_momentum_i) && $stable(saturated_i))

  // With the sink ready every stage advances, so a request is always taken.
  `SGDM_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, out_ready_i, in_ready_i)

  // An empty output register lets the whole pipeline advance.
  `SGDM_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A request is refused only while a result waits at a stalled output.
  `SGDM_ASSERT_NOW(a_refuse_on_stall, clk_i, rst_ni, in_valid_i && !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind sgd_momentum_weight_update sgdm_port_checker u_sgdm_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .new_weight_i   (new_weight_o),
  .new_gradient_i (new_gradient_o),
  .new_momentum_i (new_momentum_o),
  .saturated_i    (saturated_o)
);

`default_nettype wire

// ----- dv/sgd_momentum_weight_update_checker.sv -----
// Checker of the weight update block: tracks the registers, predicts every update, compares.
`timescale 1ns / 100ps

module sgd_momentum_weight_update_checker
  import sgdm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COEF_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [VALUE_W-1:0] weight_i,
  input  logic signed [VALUE_W-1:0] gradient_i,
  input  logic signed [VALUE_W-1:0] momentum_i,
  input  logic [SCALE_W-1:0]        step_scale_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [VALUE_W-1:0] new_weight_i,
  input  logic signed [VALUE_W-1:0] new_gradient_i,
  input  logic signed [VALUE_W-1:0] new_momentum_i,
  input  logic                      saturated_i,
  input  logic                      finish_i,
  output int                        outstanding_o,
  output int                        fail_count_o
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] weight;
    logic signed [VALUE_W-1:0] gradient;
    logic signed [VALUE_W-1:0] momentum;
    logic                      saturated;
  } update_t;

  localparam longint VAL_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  logic [COEF_W-1:0] learn_rate;
  logic [COEF_W-1:0] l2_decay;
  logic [COEF_W-1:0] l1_decay;
  logic [COEF_W-1:0] inertia;
  update_t           predicted_updates[$];
  int                fails = 0;
  int                results_seen = 0;
  bit                leftover_checked = 1'b0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] update %0d: %s", $time, results_seen, msg);
    fails++;
  endtask

  task automatic compare_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic longint clamp_value(input longint v, inout bit clipped);
    if (v > VAL_MAX) begin
      clipped = 1'b1;
      return VAL_MAX;
    end
    if (v < VAL_MIN) begin
      clipped = 1'b1;
      return VAL_MIN;
    end
    return v;
  endfunction

  // Exact product, then drop frac bits rounding half up.
  function automatic longint round_product(input longint a, input longint b,
                                           input int unsigned frac);
    return (a * b + (longint'(1) <<< (frac - 1))) >>> frac;
  endfunction

  function automatic update_t predict_update(input logic signed [VALUE_W-1:0] w_in, g_in, m_in,
                                             input logic [SCALE_W-1:0] scale_in);
    longint  w;
    longint  g;
    longint  m;
    longint  sc;
    longint  eta;
    longint  k;
    longint  nw;
    longint  l1_step;
    bit      clipped;
    update_t r;
    w       = longint'(w_in);
    g       = longint'(g_in);
    m       = longint'(m_in);
    sc      = longint'(scale_in);
    eta     = longint'(learn_rate);
    k       = longint'(inertia);
    clipped = 1'b0;
    if (l2_decay != '0) begin
      g = clamp_value(g + round_product(w, longint'(l2_decay), COEF_W), clipped);
    end
    if (l1_decay != '0) begin
      l1_step = round_product(longint'(l1_decay), longint'(1) <<< VALUE_FRAC, COEF_W);
      if (w > 0) begin
        g = clamp_value(g + l1_step, clipped);
      end else if (w < 0) begin
        g = clamp_value(g - l1_step, clipped);
      end
    end
    if (k == 0) begin
      g  = clamp_value(round_product(g, sc, SCALE_FRAC), clipped);
      nw = clamp_value(w - round_product(g, eta, COEF_W), clipped);
    end else begin
      m  = clamp_value((((longint'(1) <<< COEF_W) - k) * g + k * m
                        + (longint'(1) <<< (COEF_W - 1))) >>> COEF_W, clipped);
      m  = clamp_value(round_product(m, sc, SCALE_FRAC), clipped);
      nw = clamp_value(w - round_product(m, eta, COEF_W), clipped);
    end
    r.weight    = nw[VALUE_W-1:0];
    r.gradient  = g[VALUE_W-1:0];
    r.momentum  = m[VALUE_W-1:0];
    r.saturated = clipped;
    return r;
  endfunction

  always @(posedge clk_i) begin
    update_t want;
    if (!rst_ni) begin
      learn_rate = '0;
      l2_decay   = '0;
      l1_decay   = '0;
      inertia    = '0;
      predicted_updates.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LEARN_RATE:      learn_rate = cfg_data_i;
          REG_L2_DECAY:        l2_decay   = cfg_data_i;
          REG_L1_DECAY:        l1_decay   = cfg_data_i;
          REG_MOMENTUM_FACTOR: inertia    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predicted_updates.push_back(predict_update(weight_i, gradient_i, momentum_i,
                                                   step_scale_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_updates.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = predicted_updates.pop_front();
          compare_field("new_weight", new_weight_i, want.weight);
          compare_field("new_gradient", new_gradient_i, want.gradient);
          compare_field("new_momentum", new_momentum_i, want.momentum);
          compare_field("saturated", VALUE_W'(saturated_i), VALUE_W'(want.saturated));
        end
        results_seen++;
      end
      if (finish_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (predicted_updates.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", predicted_updates.size()));
        end
      end
      outstanding_o <= predicted_updates.size();
    end
  end

endmodule

// ----- dv/sgd_momentum_weight_update_test.sv -----
// Testbench top of the weight update block: clock, reset, register writes, requests, verdict.
`timescale 1ns / 100ps

module sgd_momentum_weight_update_test;
  import sgdm_pkg::*;

  // Run shape: directed requests first, then random phases with fresh settings.
  localparam int          PHASE_COUNT    = 12;
  localparam int          PHASE_REQUESTS = 150;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int          TAIL_CYCLES    = 12;
  // Long receiver hold-off, long enough to fill all nine stages and stall the input.
  localparam int          STALL_CYCLES   = 160;
  localparam int          STALL_EVERY    = 600;
  localparam int          STALL_AT       = 300;

  localparam logic signed [VALUE_W-1:0] VAL_MAX    = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN    = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] ONE_VALUE  = VALUE_W'(1) << VALUE_FRAC;
  localparam logic [SCALE_W-1:0]        UNIT_SCALE = SCALE_W'(1) << SCALE_FRAC;
  localparam logic [SCALE_W-1:0]        SCALE_MAX  = '1;
  localparam logic [COEF_W-1:0]         COEF_MAX   = '1;
  localparam logic [COEF_W-1:0]         COEF_HALF  = COEF_W'(1) << (COEF_W - 1);

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index    = REG_LEARN_RATE;
  logic [COEF_W-1:0]         cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] weight       = '0;
  logic signed [VALUE_W-1:0] gradient     = '0;
  logic signed [VALUE_W-1:0] momentum     = '0;
  logic [SCALE_W-1:0]        step_scale   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic signed [VALUE_W-1:0] new_weight;
  logic signed [VALUE_W-1:0] new_gradient;
  logic signed [VALUE_W-1:0] new_momentum;
  logic                      saturated;
  logic                      finish       = 1'b0;
  int                        outstanding;
  int                        fail_count;
  int unsigned               cycles       = 0;
  int                        source_streak = 0;
  int                        sink_streak   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sgd_momentum_weight_update uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .weight_i       (weight),
    .gradient_i     (gradient),
    .momentum_i     (momentum),
    .step_scale_i   (step_scale),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .new_weight_o   (new_weight),
    .new_gradient_o (new_gradient),
    .new_momentum_o (new_momentum),
    .saturated_o    (saturated)
  );

  sgd_momentum_weight_update_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .weight_i       (weight),
    .gradient_i     (gradient),
    .momentum_i     (momentum),
    .step_scale_i   (step_scale),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .new_weight_i   (new_weight),
    .new_gradient_i (new_gradient),
    .new_momentum_i (new_momentum),
    .saturated_i    (saturated),
    .finish_i       (finish),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  // Hard stop: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle gap before the next request on one side: mostly a random gap, with
  // occasional runs of back-to-back requests so the pipeline sees full rate too.
  function automatic int unsigned draw_gap(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      streak = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Mostly values of a few units in Q8.24, some full range (saturation), some edges.
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: ;
      1: begin
        case ($urandom_range(0, 4))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = v >>> $urandom_range(3, 12);
    endcase
    return v;
  endfunction

  function automatic logic [SCALE_W-1:0] random_scale();
    case ($urandom_range(0, 5))
      0:       return SCALE_W'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? SCALE_MAX : '0;
      default: return SCALE_W'($urandom_range(0, 4 * UNIT_SCALE));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_W'(1);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Offer one request; hold valid and payload until the block takes it.
  task automatic send_update(input logic signed [VALUE_W-1:0] w, g, m,
                             input logic [SCALE_W-1:0] sc);
    int unsigned gap;
    gap = draw_gap(source_streak);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    weight     <= w;
    gradient   <= g;
    momentum   <= m;
    step_scale <= sc;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid after the last request and wait until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Keep cfg_valid high across back-to-back writes; the caller lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only ever called with the block drained.
  task automatic apply_settings(input logic [COEF_W-1:0] eta, l2, l1, k);
    write_register(REG_LEARN_RATE, eta);
    write_register(REG_L2_DECAY, l2);
    write_register(REG_L1_DECAY, l1);
    write_register(REG_MOMENTUM_FACTOR, k);
    // Writes to indexes past the register list must leave everything alone.
    if ($urandom_range(0, 1) != 0) begin
      write_register(CFG_IDX_W'($urandom_range(REG_MOMENTUM_FACTOR + 1, (1 << CFG_IDX_W) - 1)),
                     COEF_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, zero and both signs of weight (L1 sign), clipping, a zero step
  // scale and ordinary values near one.
  task automatic run_directed();
    send_update('0, '0, '0, '0);
    send_update(VAL_MAX, VAL_MAX, VAL_MAX, SCALE_MAX);
    send_update(VAL_MIN, VAL_MIN, VAL_MIN, SCALE_MAX);
    send_update(VAL_MAX, VAL_MIN, VAL_MAX, '0);
    send_update(-1, 1, -1, UNIT_SCALE);
    send_update(1, -1, 1, UNIT_SCALE);
    send_update('0, ONE_VALUE, VAL_MAX, SCALE_W'(1) << (SCALE_W - 1));
    send_update(-ONE_VALUE, ONE_VALUE >>> 1, -ONE_VALUE, UNIT_SCALE);
  endtask

  // Result side: random hold-offs per result, plus long stalls while the
  // sender keeps offering, so the pipeline fills and backs up into in_ready.
  initial begin : result_sink
    int unsigned gap;
    int          taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_streak);
      if (taken % STALL_EVERY == STALL_AT) begin
        gap = STALL_CYCLES;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : request_source
    logic [COEF_W-1:0] eta;
    logic [COEF_W-1:0] l2;
    logic [COEF_W-1:0] l1;
    logic [COEF_W-1:0] k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values first: no decay, no momentum, zero step size.
    run_directed();
    drain();
    // Plain update with both decay terms.
    apply_settings(COEF_HALF, COEF_HALF >> 1, COEF_HALF >> 2, '0);
    run_directed();
    drain();
    // Every register at its maximum, momentum path.
    apply_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    run_directed();
    drain();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          eta = COEF_W'(1);
          l2  = COEF_W'(1);
          l1  = COEF_W'(1);
          k   = COEF_W'(1);
        end
        1: begin
          eta = COEF_MAX;
          l2  = '0;
          l1  = '0;
          k   = '0;
        end
        2: begin
          eta = COEF_HALF >> 2;
          l2  = '0;
          l1  = COEF_HALF >> 4;
          k   = COEF_MAX - (COEF_HALF >> 2);
        end
        default: begin
          eta = random_coef();
          l2  = random_coef();
          l1  = random_coef();
          k   = ($urandom_range(0, 2) == 0) ? '0 : random_coef();
        end
      endcase
      apply_settings(eta, l2, l1, k);
      repeat (PHASE_REQUESTS) begin
        send_update(random_value(), random_value(), random_value(), random_scale());
      end
      drain();
    end

    // Let any stray late result show up, then close the books.
    repeat (TAIL_CYCLES) @(posedge clk);
    finish <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sgd_momentum_weight_update.f -----
+incdir+rtl/core
rtl/core/sgdm_pkg.sv
rtl/core/sgdm_pipe_ctrl.sv
rtl/core/sgd_momentum_weight_update.sv
rtl/core/sgdm_port_checker.sv
dv/sgd_momentum_weight_update_checker.sv
dv/sgd_momentum_weight_update_test.sv
